// ===== design/point_in_polygon_test_top_defines.svh =====
// Assertion macros for the point-in-polygon test block.
// Used by point_in_polygon_test_top; expects clk and rst_n in scope.
`ifndef POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PIP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pip assertion failed");
`define PIP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pip assertion failed");
`else
`define PIP_ASSERT_IMP(lbl, ante, cons)
`define PIP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== design/pip_pkg.sv =====
// Shared types, constants and helper functions for the point-in-polygon test.
// No dependencies; imported by pip_orient_unit and point_in_polygon_test_top.
package pip_pkg;

  localparam int COORD_W  = 16;
  localparam int MAX_VERT = 64;
  localparam int VIDX_W   = $clog2(MAX_VERT);
  localparam int CNT_W    = 7;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CROSS_W  = PROD_W + 1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_VCOUNT = 1'b0;
  localparam logic CFG_RAYX   = 1'b1;

  localparam logic [CNT_W-1:0]          VCOUNT_RST = '0;
  localparam logic signed [COORD_W-1:0] RAYX_RST   = COORD_W'(32767);
  localparam logic [CNT_W-1:0]          MIN_VERT   = CNT_W'(3);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  typedef enum logic [1:0] {
    OR_COL = 2'd0,
    OR_CW  = 2'd1,
    OR_CCW = 2'd2
  } orient_t;

  typedef enum logic [1:0] {
    SEL_P3 = 2'd0,
    SEL_P1 = 2'd1,
    SEL_P2 = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     mul_en;
    mul_sel_t sel;
    logic     keep_p3;
    logic     keep_o1;
  } orient_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRIME,
    ST_FIRST,
    ST_LOAD,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_EVAL,
    ST_DONE
  } state_t;

  function automatic logic signed [DIFF_W-1:0] coord_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic orient_t orient_of(input logic signed [CROSS_W-1:0] v);
    if (v == '0) begin
      return OR_COL;
    end
    return v[CROSS_W-1] ? OR_CCW : OR_CW;
  endfunction

  function automatic logic in_span(
    input logic signed [COORD_W-1:0] q,
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return ((q >= a) && (q <= b)) || ((q >= b) && (q <= a));
  endfunction

endpackage

// ===== design/point_in_polygon_test_top.sv =====
// Point-in-polygon test by horizontal ray casting: top level, vertex memory, sequencer.
// Depends on pip_pkg, pip_orient_unit and point_in_polygon_test_top_defines.svh.
//
// Usage: the input channel (in_valid/in_stall) carries write items (operation 0)
// that store one vertex into slot vertex_index, and query items (operation 1)
// that test the point (coord_x, coord_y). Each query gives one result transfer
// on out_valid/out_stall; writes give none. cfg_we writes vertex_count (index 0)
// or ray_end_x (index 1); the user must do this only while the block is idle,
// which the block itself does not enforce. A write is stored and the block is
// ready again at once. A query with fewer than three vertices goes to ST_DONE
// and then to the output register. Otherwise the walk runs ST_PRIME, ST_FIRST,
// ST_LOAD, then per edge the single shared multiplier forms three products
// (ST_MUL1 to ST_MUL3) and ST_EVAL compares and counts. Only one query is in
// flight; in_stall stays high until it finishes. A collinear hit ends the walk
// early. The finished result sits in an output register, so the block takes
// new items while out_stall holds the previous result; a second finished query
// waits until that register frees up. Reset initialises the control state and
// configuration only; the vertex memory is not cleared and must be written before use.
`include "point_in_polygon_test_top_defines.svh"

module point_in_polygon_test_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [pip_pkg::COORD_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [pip_pkg::VIDX_W-1:0]          in_vertex_index,
  input  logic signed [pip_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0]  in_coord_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_inside_res,
  output logic                                out_edge_decided
);
  import pip_pkg::*;

  state_t                    state_r, state_nxt;
  logic [VIDX_W-1:0]         cursor_r, cursor_nxt;
  logic [VIDX_W-1:0]         edge_r, edge_nxt;
  vertex_t                   a_r, a_nxt, b_r, b_nxt;
  vertex_t                   rd_data_r;
  vertex_t                   vmem [MAX_VERT];
  logic signed [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [COORD_W-1:0] rayx_r, rayx_nxt;
  logic [CNT_W-1:0]          vcount_r, vcount_nxt;
  logic                      parity_r, parity_nxt;
  logic                      res_inside_r, res_inside_nxt;
  logic                      res_dec_r, res_dec_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_inside_r, out_inside_nxt;
  logic                      out_dec_r, out_dec_nxt;

  logic                      in_acc;
  logic                      few;
  logic [VIDX_W-1:0]         n_last;
  logic [VIDX_W-1:0]         cursor_adv;
  orient_ctrl_t              octrl;
  orient_t                   o1, o2, o3, o4;
  logic                      hit_ac, hit_ad, hit_ca, hit_cb;
  logic                      crosses;
  logic                      parity_upd;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign few      = (vcount_r < MIN_VERT);
  assign n_last   = (vcount_r >= CNT_W'(MAX_VERT)) ? VIDX_W'(MAX_VERT - 1)
                                                   : VIDX_W'(vcount_r - CNT_W'(1));
  assign cursor_adv = (cursor_r == n_last) ? '0 : cursor_r + VIDX_W'(1);

  always_ff @(posedge clk) begin
    if (in_acc && (in_operation == OP_WRITE)) begin
      vmem[in_vertex_index] <= '{x: in_coord_x, y: in_coord_y};
    end
    rd_data_r <= vmem[cursor_r];
  end

  pip_orient_unit u_orient (
    .clk    (clk),
    .ctrl   (octrl),
    .vert_a (a_r),
    .vert_b (b_r),
    .pt_x   (px_r),
    .pt_y   (py_r),
    .ray_x  (rayx_r),
    .o1     (o1),
    .o2     (o2)
  );

  always_comb begin
    if ((rayx_r == px_r) || (a_r.y == py_r)) begin
      o3 = OR_COL;
    end else begin
      o3 = ((rayx_r < px_r) == (a_r.y < py_r)) ? OR_CCW : OR_CW;
    end
    if ((rayx_r == px_r) || (b_r.y == py_r)) begin
      o4 = OR_COL;
    end else begin
      o4 = ((rayx_r < px_r) == (b_r.y < py_r)) ? OR_CCW : OR_CW;
    end
  end

  assign hit_ac = in_span(px_r, a_r.x, b_r.x) && in_span(py_r, a_r.y, b_r.y);
  assign hit_ad = in_span(rayx_r, a_r.x, b_r.x) && in_span(py_r, a_r.y, b_r.y);
  assign hit_ca = in_span(a_r.x, px_r, rayx_r) && (a_r.y == py_r);
  assign hit_cb = in_span(b_r.x, px_r, rayx_r) && (b_r.y == py_r);

  assign crosses = ((o1 != o2) && (o3 != o4)) ||
                   ((o1 == OR_COL) && hit_ac) || ((o2 == OR_COL) && hit_ad) ||
                   ((o3 == OR_COL) && hit_ca) || ((o4 == OR_COL) && hit_cb);
  assign parity_upd = parity_r ^ crosses;

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    edge_nxt       = edge_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    rayx_nxt       = rayx_r;
    vcount_nxt     = vcount_r;
    parity_nxt     = parity_r;
    res_inside_nxt = res_inside_r;
    res_dec_nxt    = res_dec_r;
    out_valid_nxt  = out_valid_r;
    out_inside_nxt = out_inside_r;
    out_dec_nxt    = out_dec_r;
    octrl          = '{mul_en: 1'b0, sel: SEL_P3, keep_p3: 1'b0, keep_o1: 1'b0};

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_VCOUNT: vcount_nxt = cfg_wdata[CNT_W-1:0];
        CFG_RAYX:   rayx_nxt   = cfg_wdata;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_operation == OP_QUERY)) begin
          px_nxt     = in_coord_x;
          py_nxt     = in_coord_y;
          parity_nxt = 1'b0;
          if (few) begin
            res_inside_nxt = 1'b0;
            res_dec_nxt    = 1'b0;
            state_nxt      = ST_DONE;
          end else begin
            cursor_nxt = '0;
            edge_nxt   = '0;
            state_nxt  = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        cursor_nxt = cursor_adv;
        state_nxt  = ST_FIRST;
      end
      ST_FIRST: begin
        b_nxt      = rd_data_r;
        cursor_nxt = cursor_adv;
        state_nxt  = ST_LOAD;
      end
      ST_LOAD: begin
        a_nxt     = b_r;
        b_nxt     = rd_data_r;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        octrl     = '{mul_en: 1'b1, sel: SEL_P3, keep_p3: 1'b0, keep_o1: 1'b0};
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        octrl     = '{mul_en: 1'b1, sel: SEL_P1, keep_p3: 1'b1, keep_o1: 1'b0};
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        octrl     = '{mul_en: 1'b1, sel: SEL_P2, keep_p3: 1'b0, keep_o1: 1'b1};
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (crosses && (o1 == OR_COL)) begin
          res_inside_nxt = hit_ac;
          res_dec_nxt    = 1'b1;
          state_nxt      = ST_DONE;
        end else if (edge_r == n_last) begin
          res_inside_nxt = parity_upd;
          res_dec_nxt    = 1'b0;
          state_nxt      = ST_DONE;
        end else begin
          parity_nxt = parity_upd;
          edge_nxt   = edge_r + VIDX_W'(1);
          a_nxt      = b_r;
          b_nxt      = rd_data_r;
          cursor_nxt = cursor_adv;
          state_nxt  = ST_MUL1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = res_inside_r;
          out_dec_nxt    = res_dec_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      edge_r      <= '0;
      vcount_r    <= VCOUNT_RST;
      rayx_r      <= RAYX_RST;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      edge_r      <= edge_nxt;
      vcount_r    <= vcount_nxt;
      rayx_r      <= rayx_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    res_inside_r <= res_inside_nxt;
    res_dec_r    <= res_dec_nxt;
    out_inside_r <= out_inside_nxt;
    out_dec_r    <= out_dec_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_inside_res   = out_inside_r;
  assign out_edge_decided = out_dec_r;

  `PIP_ASSERT_IMP(a_rise_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE)
  `PIP_ASSERT_IMP(a_edge_in_range, state_r == ST_EVAL, edge_r <= n_last)
  `PIP_ASSERT_NXT(a_query_walks, in_acc && (in_operation == OP_QUERY) && !few, state_r == ST_PRIME)
  `PIP_ASSERT_NXT(a_few_skips, in_acc && (in_operation == OP_QUERY) && few, state_r == ST_DONE)

endmodule

// ===== design/pip_orient_unit.sv =====
// Shared 17x17 multiplier and orientation sign unit for one polygon edge.
// Depends on pip_pkg; sequenced by point_in_polygon_test_top.
module pip_orient_unit (
  input  logic                 clk,
  input  pip_pkg::orient_ctrl_t ctrl,
  input  pip_pkg::vertex_t     vert_a,
  input  pip_pkg::vertex_t     vert_b,
  input  logic signed [pip_pkg::COORD_W-1:0] pt_x,
  input  logic signed [pip_pkg::COORD_W-1:0] pt_y,
  input  logic signed [pip_pkg::COORD_W-1:0] ray_x,
  output pip_pkg::orient_t     o1,
  output pip_pkg::orient_t     o2
);
  import pip_pkg::*;

  logic signed [DIFF_W-1:0]  opa, opb;
  logic signed [PROD_W-1:0]  mult;
  logic signed [PROD_W-1:0]  prod_r, p3_r;
  logic signed [CROSS_W-1:0] cross_v;
  orient_t                   o1_r;

  always_comb begin
    unique case (ctrl.sel)
      SEL_P3: begin
        opa = coord_diff(vert_b.x, vert_a.x);
        opb = coord_diff(pt_y, vert_b.y);
      end
      SEL_P1: begin
        opa = coord_diff(vert_b.y, vert_a.y);
        opb = coord_diff(pt_x, vert_b.x);
      end
      SEL_P2: begin
        opa = coord_diff(vert_b.y, vert_a.y);
        opb = coord_diff(ray_x, vert_b.x);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mult    = opa * opb;
  assign cross_v = CROSS_W'(prod_r) - CROSS_W'(p3_r);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mult;
    end
    if (ctrl.keep_p3) begin
      p3_r <= prod_r;
    end
    if (ctrl.keep_o1) begin
      o1_r <= orient_of(cross_v);
    end
  end

  assign o1 = o1_r;
  assign o2 = orient_of(cross_v);

endmodule
